FILE: hw/rtl/lpcl_pkg.sv
// Package for the length-prefixed card list matcher.
// Holds the sizing defaults, the opcode codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpcl_pkg;

  // Default sizing of the record table and the card buffer.
  localparam int unsigned LpclTableBytes   = 256;
  localparam int unsigned LpclMaxCardBytes = 16;

  // Input item kinds.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CARD  = 1'b1
  } lpcl_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN,
    ST_LCHK,
    ST_CMP,
    ST_CCHK,
    ST_DONE
  } lpcl_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/length_prefixed_card_list_match_unit.sv
// Length-prefixed card list matcher, top level.
// Table writes and non-final card bytes are taken while idle. A final byte of a card
// that fits walks the table memory, reading and checking the length byte of each
// record visited and each compared card byte, then loads the result register, held
// while an earlier result still waits there; an overlong card skips the walk. After
// reset the table is cleared and no input transfer is taken until then. Uses lpcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_card_list_match_unit
  import lpcl_pkg::*;
#(
  parameter int unsigned TABLE_BYTES    = LpclTableBytes,
  parameter int unsigned MAX_CARD_BYTES = LpclMaxCardBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // opcode[0], table_address[8:1], data_byte[16:9]
  input  wire logic        s_axis_tlast_i,  // is_last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // match[0]
  output logic [0:0]       m_axis_tuser_o   // too_long[0]
);

  localparam int unsigned AW  = $clog2(TABLE_BYTES);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned SW  = ((AW > 8) ? AW : 8) + 1;
  localparam int unsigned LW  = $clog2(MAX_CARD_BYTES + 1);
  localparam int unsigned BIW = (MAX_CARD_BYTES > 1) ? $clog2(MAX_CARD_BYTES) : 1;

  // Input field decode.
  lpcl_op_e   in_op;
  logic [7:0] in_addr;
  logic [7:0] in_byte;
  assign in_op   = lpcl_op_e'(s_axis_tdata_i[0]);
  assign in_addr = s_axis_tdata_i[8:1];
  assign in_byte = s_axis_tdata_i[16:9];

  lpcl_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [LW-1:0] card_len_q, card_len_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  logic          out_match_q, out_match_d;
  logic          out_long_q, out_long_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] nxt_q, nxt_d;
  logic [LW-1:0] idx_q, idx_d;
  logic          res_match_q, res_match_d;
  logic          res_long_q, res_long_d;

  logic [7:0] card_mem_q [MAX_CARD_BYTES];
  logic           card_we;
  logic [BIW-1:0] card_widx;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          in_fire;
  logic          card_full;
  logic [SW-1:0] nxt_sum;
  logic [SW-1:0] data_addr;
  logic [SW-1:0] wr_addr_ext;

  lpcl_table_ram #(
    .Depth (TABLE_BYTES),
    .AddrW (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign card_full   = (card_len_q == LW'(MAX_CARD_BYTES));
  assign nxt_sum     = SW'(pos_q) + SW'(ram_rdata) + SW'(1);
  assign data_addr   = SW'(pos_q) + SW'(idx_q) + SW'(1);
  assign wr_addr_ext = SW'(in_addr);
  assign card_widx   = card_len_q[BIW-1:0];

  // Next state, memory access and result selection.
  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    card_len_d      = card_len_q;
    ovf_d           = ovf_q;
    out_valid_d     = out_valid_q;
    out_match_d     = out_match_q;
    out_long_d      = out_long_q;
    pos_d           = pos_q;
    nxt_d           = nxt_q;
    idx_d           = idx_q;
    res_match_d     = res_match_q;
    res_long_d      = res_long_q;
    ram_we          = 1'b0;
    ram_addr        = pos_q[AW-1:0];
    ram_wdata       = in_byte;
    card_we         = 1'b0;
    s_axis_tready_o = 1'b0;

    // The result register empties on its output transfer.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'd0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_fire) begin
          if (in_op == OP_WRITE) begin
            ram_addr = wr_addr_ext[AW-1:0];
            ram_we   = (wr_addr_ext < SW'(TABLE_BYTES));
          end else begin
            if (!card_full) begin
              card_we    = 1'b1;
              card_len_d = card_len_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            if (s_axis_tlast_i) begin
              if (ovf_q || card_full) begin
                res_match_d = 1'b0;
                res_long_d  = 1'b1;
                state_d     = ST_DONE;
              end else begin
                pos_d   = '0;
                state_d = ST_LEN;
              end
            end
          end
        end
      end
      ST_LEN: begin
        ram_addr = pos_q[AW-1:0];
        state_d  = ST_LCHK;
      end
      ST_LCHK: begin
        // Length byte is in the read register.
        res_match_d = 1'b0;
        res_long_d  = 1'b0;
        if ((ram_rdata == 8'd0) || (nxt_sum > SW'(TABLE_BYTES))) begin
          state_d = ST_DONE;
        end else begin
          nxt_d = nxt_sum[PW-1:0];
          if (9'({1'b0, ram_rdata}) == 9'(card_len_q)) begin
            idx_d   = '0;
            state_d = ST_CMP;
          end else begin
            pos_d = nxt_sum[PW-1:0];
            if (nxt_sum == SW'(TABLE_BYTES)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_LEN;
            end
          end
        end
      end
      ST_CMP: begin
        ram_addr = data_addr[AW-1:0];
        state_d  = ST_CCHK;
      end
      ST_CCHK: begin
        if (ram_rdata != card_mem_q[idx_q[BIW-1:0]]) begin
          // Mismatch: move on to the next record.
          pos_d = nxt_q;
          if (nxt_q == PW'(TABLE_BYTES)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_LEN;
          end
        end else if (idx_q == card_len_q - LW'(1)) begin
          res_match_d = 1'b1;
          state_d     = ST_DONE;
        end else begin
          idx_d   = idx_q + LW'(1);
          state_d = ST_CMP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_match_d = res_match_q;
          out_long_d  = res_long_q;
          card_len_d  = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      card_len_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      card_len_q  <= card_len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    nxt_q       <= nxt_d;
    idx_q       <= idx_d;
    res_match_q <= res_match_d;
    res_long_q  <= res_long_d;
    out_match_q <= out_match_d;
    out_long_q  <= out_long_d;
  end

  // Card byte buffer.
  always_ff @(posedge clk_i) begin
    if (card_we) begin
      card_mem_q[card_widx] <= in_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_match_q};
  assign m_axis_tuser_o  = out_long_q;

  // A result never claims both a match and an overlong card.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tuser_o[0]))
    else $error("match and too_long set together");

  // No input is taken while the table is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("input taken during table clear");

  // A final card byte stalls the input while its lookup runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op == OP_CARD) && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input ready right after final card byte");

  // A table write never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op == OP_WRITE) && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result after table write");

endmodule

`default_nettype wire

FILE: hw/rtl/lpcl_table_ram.sv
// Single-port synchronous record table memory with a registered read.
// Uses lpcl_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module lpcl_table_ram
  import lpcl_pkg::*;
#(
  parameter int unsigned Depth = LpclTableBytes,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];

  // Write port and registered read of the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: tb/length_prefixed_card_list_match_unit_tb.sv
// Self-checking testbench for the length-prefixed card list matcher.
// Builds record lists, presents cards and checks match and too_long flags
// against an in-bench predictor. Depends on lpcl_pkg and the matcher top level.
`timescale 1ns / 1ps

module length_prefixed_card_list_match_unit_tb;
  import lpcl_pkg::*;

  localparam int unsigned TableBytes   = LpclTableBytes;
  localparam int unsigned MaxCardBytes = LpclMaxCardBytes;
  localparam int unsigned ItemTarget   = 1350;
  localparam int unsigned SettleCycles = 1000;
  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned ReportLimit  = 50;

  // One input transfer as the generator sees it.
  typedef struct packed {
    lpcl_op_e   op;
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } lpcl_item_t;

  // One lookup outcome.
  typedef struct packed {
    logic match;
    logic too_long;
  } verdict_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;  // opcode[0], table_address[8:1], data_byte[16:9]
  logic        s_axis_tlast_i  = 1'b0;  // is_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;  // match[0]
  logic [0:0]  m_axis_tuser_o;  // too_long[0]

  length_prefixed_card_list_match_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: the table and the card being collected.
  logic [7:0]  model_table [TableBytes];
  logic [7:0]  model_card  [MaxCardBytes];
  int unsigned model_card_len = 0;
  logic        model_card_ovf = 1'b0;

  // Generator copy of the table, used to derive cards that hit stored records.
  logic [7:0]  gen_table [TableBytes];

  lpcl_item_t  pending_items[$];
  verdict_t    verdict_q[$];
  int unsigned item_total  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_burst = 1'b0;
  bit          recv_burst   = 1'b0;

  // Driver and monitor working variables.
  lpcl_item_t  drv_item = '0;
  bit          drv_busy = 1'b0;
  int unsigned drv_gap  = 0;
  int unsigned ready_hold = 0;
  verdict_t    seen_verdict;

  initial begin
    for (int i = 0; i < TableBytes; i++) begin
      model_table[i] = 8'h00;
      gen_table[i]   = 8'h00;
    end
    for (int i = 0; i < MaxCardBytes; i++) model_card[i] = 8'h00;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Walk the records from offset 0 and look for one equal to the card.
  function automatic logic table_holds_card();
    int unsigned pos;
    int unsigned len;
    logic        same;
    pos = 0;
    while (pos < TableBytes) begin
      len = model_table[pos];
      if (len == 0) return 1'b0;
      if (pos + len + 1 > TableBytes) return 1'b0;
      if (len == model_card_len) begin
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (model_table[pos + 1 + k] != model_card[k]) same = 1'b0;
        end
        if (same) return 1'b1;
      end
      pos += len + 1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted transfer and queue the verdict it produces, if any.
  task automatic predict_verdict(input lpcl_item_t item);
    verdict_t v;
    if (item.op == OP_WRITE) begin
      if (int'(item.addr) < TableBytes) model_table[item.addr] = item.data;
    end else begin
      if (model_card_len < MaxCardBytes) begin
        model_card[model_card_len] = item.data;
        model_card_len++;
      end else begin
        model_card_ovf = 1'b1;
      end
      if (item.last) begin
        v.too_long = model_card_ovf;
        v.match    = model_card_ovf ? 1'b0 : table_holds_card();
        verdict_q.push_back(v);
        model_card_len = 0;
        model_card_ovf = 1'b0;
      end
    end
  endtask

  task automatic push_write(input int unsigned addr, input int unsigned data);
    lpcl_item_t item;
    item.op   = OP_WRITE;
    item.addr = 8'(addr);
    item.data = 8'(data);
    item.last = 1'($urandom_range(0, 1));
    gen_table[item.addr] = item.data;
    pending_items.push_back(item);
    item_total++;
  endtask

  task automatic push_card_byte(input logic [7:0] data, input logic last);
    lpcl_item_t item;
    item.op   = OP_CARD;
    item.addr = 8'($urandom_range(0, 255));
    item.data = data;
    item.last = last;
    pending_items.push_back(item);
    item_total++;
  endtask

  // Hold the sender until every queued transfer is taken and every verdict is in.
  task automatic drain_all();
    while (pending_items.size() != 0 || drv_busy || verdict_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: presents queued transfers with random gaps between them.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_verdict(drv_item);
        drv_busy = 1'b0;
        drv_gap  = pick_gap(sender_burst);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_items.size() > 0) begin
          drv_item = pending_items.pop_front();
          drv_busy = 1'b1;
        end
      end
      s_axis_tvalid_i <= drv_busy;
      s_axis_tdata_i  <= {7'b0, drv_item.data, drv_item.addr, drv_item.op};
      s_axis_tlast_i  <= drv_item.last;
    end
  end

  // Monitor: checks each result transfer and stalls the result side at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (verdict_q.size() == 0) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("%0t: unexpected result, expected none, got match=%0b too_long=%0b",
                     $time, m_axis_tdata_o[0], m_axis_tuser_o[0]);
        end else begin
          seen_verdict = verdict_q.pop_front();
          if (m_axis_tdata_o[0] !== seen_verdict.match) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display("%0t: match mismatch, expected %0b, got %0b",
                       $time, seen_verdict.match, m_axis_tdata_o[0]);
          end
          if (m_axis_tuser_o[0] !== seen_verdict.too_long) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display("%0t: too_long mismatch, expected %0b, got %0b",
                       $time, seen_verdict.too_long, m_axis_tuser_o[0]);
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!recv_burst && $urandom_range(0, 3) == 0) ready_hold = pick_gap(1'b0);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: a directed list first, then random record lists and cards.
  initial begin
    int unsigned nrec;
    int unsigned nfit;
    int unsigned pos;
    int unsigned len;
    int unsigned ncards;
    int unsigned kind;
    int unsigned pick;
    int unsigned n;
    int unsigned rec_pos [32];
    int unsigned rec_len [32];
    logic [7:0]  card_bytes [32];

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table after the clearing pass: nothing can match.
    push_card_byte(8'h00, 1'b1);
    // One-byte record at offset 0.
    push_write(0, 1);
    push_write(1, 8'hFF);
    push_card_byte(8'hFF, 1'b1);
    // A long record skips to a two-byte record that ends exactly at the table end.
    push_write(2, 250);
    push_write(253, 2);
    push_write(254, 8'hAA);
    push_write(255, 8'h55);
    push_card_byte(8'hAA, 1'b0);
    push_card_byte(8'h55, 1'b1);
    // The same record grown past the table end stops the walk.
    push_write(253, 3);
    push_card_byte(8'hAA, 1'b0);
    push_card_byte(8'h55, 1'b1);
    // One byte more than the card buffer holds, then a normal card again.
    for (int k = 0; k <= MaxCardBytes; k++)
      push_card_byte(8'(k * 17), k == MaxCardBytes);
    push_card_byte(8'hFF, 1'b1);
    drain_all();

    while (item_total < ItemTarget) begin
      sender_burst = ($urandom_range(0, 4) == 0);
      recv_burst   = ($urandom_range(0, 4) == 0);

      // Stray writes anywhere in the table.
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) push_write($urandom_range(0, 255), $urandom_range(0, 255));

      // Build a chained record list from offset 0.
      nrec = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      pos  = 0;
      nfit = 0;
      if ($urandom_range(0, 5) == 0) begin
        // Long leading record pushes the rest of the list toward the table end.
        len = $urandom_range(150, 240);
        push_write(0, len);
        pos = len + 1;
      end
      for (int r = 0; r < nrec && pos < TableBytes; r++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        push_write(pos, len);
        if (pos + len + 1 > TableBytes) begin
          pos = TableBytes;
        end else begin
          for (int k = 0; k < len; k++) push_write(pos + 1 + k, $urandom_range(0, 255));
          if (len <= MaxCardBytes) begin
            rec_pos[nfit] = pos;
            rec_len[nfit] = len;
            nfit++;
          end
          pos += len + 1;
        end
      end
      // Usually close the list; otherwise older table bytes carry the walk on.
      if (pos < TableBytes && $urandom_range(0, 5) != 0) push_write(pos, 0);

      // Cards: mostly copies of stored records, some altered, some random or too long.
      ncards = $urandom_range(3, 10);
      for (int c = 0; c < ncards; c++) begin
        kind = $urandom_range(0, 99);
        if (nfit > 0 && kind < 70) begin
          pick = $urandom_range(0, nfit - 1);
          n    = rec_len[pick];
          for (int k = 0; k < n; k++) card_bytes[k] = gen_table[rec_pos[pick] + 1 + k];
          if (kind >= 55 && kind < 63) begin
            pick = $urandom_range(0, n - 1);
            card_bytes[pick] ^= 8'(1 << $urandom_range(0, 7));
          end else if (kind >= 63) begin
            if (n < MaxCardBytes && $urandom_range(0, 1) == 1) begin
              card_bytes[n] = 8'($urandom_range(0, 255));
              n++;
            end else if (n > 1) begin
              n--;
            end
          end
        end else begin
          n = (kind < 88) ? $urandom_range(1, MaxCardBytes)
                          : $urandom_range(MaxCardBytes + 1, MaxCardBytes + 8);
          for (int k = 0; k < n; k++) card_bytes[k] = 8'($urandom_range(0, 255));
        end
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 30) == 0)
            push_write($urandom_range(0, 255), $urandom_range(0, 255));
          push_card_byte(card_bytes[k], k == n - 1);
        end
      end

      // Let the phase play out; now and then also wait for every verdict.
      while (pending_items.size() != 0) @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) drain_all();
    end

    drain_all();
    repeat (SettleCycles) @(posedge clk_i);
    // Every predicted verdict must have been seen on the result side.
    if (verdict_q.size() != 0) begin
      error_count++;
      $display("%0t: missing results, expected %0d more, got none",
               $time, verdict_q.size());
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lpcl_pkg.sv
hw/rtl/lpcl_table_ram.sv
hw/rtl/length_prefixed_card_list_match_unit.sv
tb/length_prefixed_card_list_match_unit_tb.sv
